// ----- rtl/iprds_pkg.sv -----
// Shared types, limits and codes for the integer pixel replicate/decimate scaler.
package iprds_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int MaxFactor = 64;

  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int WidthW   = ColW + 1;
  localparam int HeightW  = RowW + 1;
  localparam int PhaseW   = $clog2(MaxFactor);
  localparam int FactorW  = PhaseW + 1;
  localparam int CfgDataW = (WidthW > HeightW) ? WidthW : HeightW;
  localparam int PadW     = 2;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    CfgModeDown = 2'd0,
    CfgFactor   = 2'd1,
    CfgWidth    = 2'd2,
    CfgHeight   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_word_t;

  typedef struct packed {
    logic [7:0]      out_blue;
    logic [7:0]      out_green;
    logic [7:0]      out_red;
    logic [PadW-1:0] pad_count;
    logic            row_last;
    logic            frame_last;
  } out_word_t;

  // Effective (already clamped) configuration.
  typedef struct packed {
    logic               mode_down;
    logic [FactorW-1:0] factor;
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
  } cfg_t;

  // One queued job: a pixel and how many extra copies to emit.
  typedef struct packed {
    in_word_t          pixel;
    logic [PhaseW-1:0] reps;
    logic              row_last;
    logic              frame_last;
    logic [PadW-1:0]   pad;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/integer_pixel_replicate_decimate_scaler.sv -----
// Path: an accepted pixel is written into the job queue and then loaded into the output register.
// Throughput: one output word per cycle while the output is not stalled and a job is queued;
// the back end's copy counter sets the input rate in enlarge mode, and shrink mode takes one source
// pixel per cycle until the 4-entry job queue fills; the queue lets input keep flowing while the output is stalled.
// Reset: asynchronous, active low; config returns to enlarge by 1 on a 1x1 image,
// position counters clear and the queue empties. Any config write restarts the frame.
module integer_pixel_replicate_decimate_scaler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  iprds_pkg::in_word_t          in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output iprds_pkg::out_word_t         out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  iprds_pkg::cfg_idx_e          cfg_index_i,
  input  logic [iprds_pkg::CfgDataW-1:0] cfg_data_i
);
  import iprds_pkg::*;

  cfg_t      cfg_q;
  logic      cfg_write;
  logic      push, pop;
  cmd_t      push_cmd, head;
  q_status_t q_status;

  logic [FactorW-1:0] fac_raw;
  logic [WidthW-1:0]  wid_raw;
  logic [HeightW-1:0] hgt_raw;

  // Config writes are always taken; hold them to idle periods upstream.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign fac_raw     = cfg_data_i[FactorW-1:0];
  assign wid_raw     = cfg_data_i[WidthW-1:0];
  assign hgt_raw     = cfg_data_i[HeightW-1:0];

  // Store clamped values so the datapath never sees a zero or oversized setting.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_down <= 1'b0;
      cfg_q.factor    <= FactorW'(1);
      cfg_q.width     <= WidthW'(1);
      cfg_q.height    <= HeightW'(1);
    end else if (cfg_write) begin
      case (cfg_index_i)
        CfgModeDown: cfg_q.mode_down <= cfg_data_i[0];
        CfgFactor: begin
          if (fac_raw == '0) cfg_q.factor <= FactorW'(1);
          else if (fac_raw > FactorW'(MaxFactor)) cfg_q.factor <= FactorW'(MaxFactor);
          else cfg_q.factor <= fac_raw;
        end
        CfgWidth: begin
          if (wid_raw == '0) cfg_q.width <= WidthW'(1);
          else if (wid_raw > WidthW'(MaxWidth)) cfg_q.width <= WidthW'(MaxWidth);
          else cfg_q.width <= wid_raw;
        end
        CfgHeight: begin
          if (hgt_raw == '0) cfg_q.height <= HeightW'(1);
          else if (hgt_raw > HeightW'(MaxHeight)) cfg_q.height <= HeightW'(MaxHeight);
          else cfg_q.height <= hgt_raw;
        end
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Front end: position tracking and keep/replicate decision per source word.
  iprds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_clear_i (cfg_write),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decouple the two sides so each can stall on its own.
  iprds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // Back end: emit each job's copies, one output word per cycle while the output is not stalled.
  iprds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  a_frame_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_last |-> out_word_o.row_last)
    else $error("frame end word without row end");

  a_pad_only_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.row_last |-> out_word_o.pad_count == '0)
    else $error("padding outside row end");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("job pushed into full queue");
`endif

endmodule

// ----- rtl/iprds_front.sv -----
// Front end: accepts source pixels, tracks position and classifies each into a job.
module iprds_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iprds_pkg::cfg_t    cfg_i,
  input  logic               cfg_clear_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iprds_pkg::in_word_t in_word_i,
  input  iprds_pkg::q_status_t q_status_i,
  output logic               push_o,
  output iprds_pkg::cmd_t    cmd_o
);
  import iprds_pkg::*;

  logic [ColW-1:0]   src_col_q, src_col_d;
  logic [RowW-1:0]   src_row_q, src_row_d;
  logic [PhaseW-1:0] row_pass_q, row_pass_d;
  logic [PhaseW-1:0] col_phase_q, col_phase_d;
  logic [PhaseW-1:0] row_phase_q, row_phase_d;
  logic [1:0]        out_col_q, out_col_d;

  logic accept, col_end, row_end, pass_end;
  logic col_fit, row_fit, col_rl, row_rl, kept;
  logic [WidthW:0]    col_sum, col_sum2;
  logic [HeightW:0]   row_sum, row_sum2;
  logic [FactorW-1:0] col_ph_inc, row_ph_inc;
  logic [3:0]         pad_mul;

  always_comb begin
    accept   = in_valid_i && !q_status_i.full;
    col_end  = {1'b0, src_col_q} >= (cfg_i.width - WidthW'(1));
    row_end  = {1'b0, src_row_q} >= (cfg_i.height - HeightW'(1));
    pass_end = {1'b0, row_pass_q} >= (cfg_i.factor - FactorW'(1));

    // At phase zero the source column is out_col * k, so these sums test
    // whether this group and the next one still fit inside the source.
    col_sum  = (WidthW+1)'(src_col_q) + (WidthW+1)'(cfg_i.factor);
    col_sum2 = col_sum + (WidthW+1)'(cfg_i.factor);
    row_sum  = (HeightW+1)'(src_row_q) + (HeightW+1)'(cfg_i.factor);
    row_sum2 = row_sum + (HeightW+1)'(cfg_i.factor);
    col_fit  = col_sum <= (WidthW+1)'(cfg_i.width);
    row_fit  = row_sum <= (HeightW+1)'(cfg_i.height);
    col_rl   = col_sum2 > (WidthW+1)'(cfg_i.width);
    row_rl   = row_sum2 > (HeightW+1)'(cfg_i.height);
    kept     = (col_phase_q == '0) && (row_phase_q == '0) && col_fit && row_fit;

    pad_mul    = 4'(cfg_i.width[1:0]) * 4'(cfg_i.factor[1:0]);
    col_ph_inc = FactorW'(col_phase_q) + FactorW'(1);
    row_ph_inc = FactorW'(row_phase_q) + FactorW'(1);

    cmd_o.pixel = in_word_i;
    if (!cfg_i.mode_down) begin
      cmd_o.reps       = PhaseW'(cfg_i.factor - FactorW'(1));
      cmd_o.row_last   = col_end;
      cmd_o.frame_last = col_end && pass_end && row_end;
      cmd_o.pad        = pad_mul[1:0];
    end else begin
      cmd_o.reps       = '0;
      cmd_o.row_last   = col_rl;
      cmd_o.frame_last = col_rl && row_rl;
      cmd_o.pad        = out_col_q + 2'd1;
    end
    push_o     = accept && (!cfg_i.mode_down || kept);
    in_stall_o = q_status_i.full;

    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    row_pass_d  = row_pass_q;
    col_phase_d = col_phase_q;
    row_phase_d = row_phase_q;
    out_col_d   = out_col_q;
    if (!cfg_i.mode_down) begin
      if (!col_end) begin
        src_col_d = src_col_q + ColW'(1);
      end else begin
        src_col_d = '0;
        if (!pass_end) begin
          row_pass_d = row_pass_q + PhaseW'(1);
        end else begin
          row_pass_d = '0;
          src_row_d  = row_end ? '0 : src_row_q + RowW'(1);
        end
      end
    end else begin
      if (!col_end) begin
        src_col_d = src_col_q + ColW'(1);
        if (col_ph_inc >= cfg_i.factor) begin
          col_phase_d = '0;
          out_col_d   = out_col_q + 2'd1;
        end else begin
          col_phase_d = col_ph_inc[PhaseW-1:0];
        end
      end else begin
        src_col_d   = '0;
        col_phase_d = '0;
        out_col_d   = '0;
        if (row_end) begin
          src_row_d   = '0;
          row_phase_d = '0;
        end else begin
          src_row_d   = src_row_q + RowW'(1);
          row_phase_d = (row_ph_inc >= cfg_i.factor) ? '0 : row_ph_inc[PhaseW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      row_pass_q  <= '0;
      col_phase_q <= '0;
      row_phase_q <= '0;
      out_col_q   <= '0;
    end else if (cfg_clear_i) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      row_pass_q  <= '0;
      col_phase_q <= '0;
      row_phase_q <= '0;
      out_col_q   <= '0;
    end else if (accept) begin
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      row_pass_q  <= row_pass_d;
      col_phase_q <= col_phase_d;
      row_phase_q <= row_phase_d;
      out_col_q   <= out_col_d;
    end
  end

endmodule

// ----- rtl/iprds_queue.sv -----
// Short job queue between the front end and the back end.
module iprds_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  iprds_pkg::cmd_t      push_cmd_i,
  input  logic                 pop_i,
  output iprds_pkg::cmd_t      head_o,
  output iprds_pkg::q_status_t status_o
);
  import iprds_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  always_comb begin
    status_o.full  = count_q == QCntW'(QDepth);
    status_o.empty = count_q == '0;
    do_push        = push_i && !status_o.full;
    do_pop         = pop_i && !status_o.empty;
    head_o         = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/iprds_back.sv -----
// Back end: replays each queued job into output words through an output register.
module iprds_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iprds_pkg::cmd_t      head_i,
  input  iprds_pkg::q_status_t q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output iprds_pkg::out_word_t out_word_o
);
  import iprds_pkg::*;

  logic [PhaseW-1:0] rep_q;
  logic              out_valid_q;
  out_word_t         out_word_q, out_word_d;
  logic              can_load, last_rep;

  always_comb begin
    can_load = !out_valid_q || !out_stall_i;
    last_rep = rep_q == head_i.reps;
    pop_o    = can_load && !q_status_i.empty && last_rep;

    out_word_d.out_blue   = head_i.pixel.blue;
    out_word_d.out_green  = head_i.pixel.green;
    out_word_d.out_red    = head_i.pixel.red;
    out_word_d.row_last   = head_i.row_last && last_rep;
    out_word_d.frame_last = head_i.frame_last && last_rep;
    out_word_d.pad_count  = out_word_d.row_last ? head_i.pad : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rep_q       <= '0;
    end else if (can_load) begin
      out_valid_q <= !q_status_i.empty;
      if (!q_status_i.empty) begin
        rep_q <= last_rep ? '0 : rep_q + PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load && !q_status_i.empty) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
